// ===== sv/i2c_master_transfer_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - assertion macros
// Concurrent checks clocked on clk and masked while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define I2CMS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define I2CMS_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define I2CMS_ASSERT(label, prop, msg)
`define I2CMS_NEVER(label, cond, msg)
`endif
`endif

// ===== sv/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - package
// Word types, event codes, status codes and register indices.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	localparam logic [1:0] OP_TX_SLOT = 2'd0;
	localparam logic [1:0] OP_RX_BYTE = 2'd1;
	localparam logic [1:0] OP_STOP    = 2'd2;
	localparam logic [1:0] OP_ABORT   = 2'd3;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_ARB   = 3'd1;
	localparam logic [2:0] ST_ADDR  = 3'd2;
	localparam logic [2:0] ST_DATA  = 3'd3;
	localparam logic [2:0] ST_ABORT = 3'd4;
	localparam logic [2:0] ST_LEN   = 3'd5;

	localparam logic [1:0] CFG_WRITE_LENGTH = 2'd0;
	localparam logic [1:0] CFG_READ_LENGTH  = 2'd1;
	localparam logic [1:0] CFG_TOTAL_LENGTH = 2'd2;

	localparam int CFG_DATA_W = 9;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] tx_byte;
		logic [7:0] rx_byte;
		logic [7:0] rx_level;
		logic       arbitration_lost;
		logic       address_nack;
		logic       data_nack;
	} evt_in_t;

	// classified word held in the queue
	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data;
		logic [7:0] rx_level;
		logic [2:0] abort_status;
	} evt_t;

	typedef struct packed {
		logic       command_valid;
		logic       command_is_read;
		logic       command_restart;
		logic       command_stop;
		logic [7:0] command_data;
		logic       commands_finished;
		logic       read_valid;
		logic [7:0] read_data;
		logic       transfer_done;
		logic [2:0] result_status;
		logic       reset_request;
	} res_t;

endpackage

// ===== sv/i2cms_front.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - front end
// Takes event words, picks the byte that matters and ranks the abort source.
// ----------------------------------------------------------------------------
module i2cms_front import i2cms_pkg::*; (
	input  evt_in_t evt,
	input  logic    evt_valid,
	output logic    evt_ready,
	input  logic    full,
	output logic    push,
	output evt_t    push_word
);

	logic [2:0] abort_status;

	always_comb begin
		if (evt.arbitration_lost) begin
			abort_status = ST_ARB;
		end else if (evt.address_nack) begin
			abort_status = ST_ADDR;
		end else if (evt.data_nack) begin
			abort_status = ST_DATA;
		end else begin
			abort_status = ST_ABORT;
		end
	end

	assign evt_ready = !full;
	assign push      = evt_valid && !full;

	assign push_word.opcode       = evt.opcode;
	assign push_word.data         = (evt.opcode == OP_RX_BYTE) ? evt.rx_byte : evt.tx_byte;
	assign push_word.rx_level     = evt.rx_level;
	assign push_word.abort_status = abort_status;

endmodule

// ===== sv/i2cms_queue.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - event queue
// Small FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module i2cms_queue import i2cms_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  evt_t push_word,
	output logic full,
	input  logic pop,
	output evt_t pop_word,
	output logic empty
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	evt_t             mem_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		r = (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/i2cms_back.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - back end
// Holds the lengths and transfer state, executes one word a cycle while the result register is free or being read.
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_assert.svh"
module i2cms_back import i2cms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  empty,
	input  evt_t                  pop_word,
	output logic                  pop,
	output res_t                  res,
	output logic                  res_valid,
	input  logic                  res_ready
);

	logic [7:0] write_length_q;
	logic [7:0] read_length_q;
	logic [8:0] total_length_q;

	logic [8:0] cmd_q;
	logic [7:0] rcv_q;
	logic [2:0] status_q;
	logic       done_q;

	logic       res_valid_q;
	res_t       res_q;

	logic [8:0] cmd_n;
	logic [7:0] rcv_n;
	logic [2:0] status_n;
	logic       done_n;
	logic [8:0] cmd_inc;
	logic [8:0] rx_sum;
	res_t       res_n;

	assign pop       = !empty && (!res_valid_q || res_ready);
	assign cmd_inc   = cmd_q + 9'd1;
	assign rx_sum    = {1'b0, rcv_q} + {1'b0, pop_word.rx_level};
	assign res       = res_q;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd_n    = cmd_q;
		rcv_n    = rcv_q;
		status_n = status_q;
		done_n   = done_q;
		res_n    = '0;
		if (!done_q) begin
			case (pop_word.opcode)
				OP_TX_SLOT: begin
					if (cmd_q < total_length_q) begin
						res_n.command_valid = 1'b1;
						res_n.command_stop  = (cmd_inc == total_length_q);
						if (cmd_q < {1'b0, write_length_q}) begin
							res_n.command_data = pop_word.data;
						end else begin
							res_n.command_is_read = 1'b1;
							// repeated start only on the turn from writes to reads
							res_n.command_restart = (cmd_q == {1'b0, write_length_q}) &&
								(write_length_q != 8'd0);
						end
						cmd_n = cmd_inc;
					end
				end
				OP_RX_BYTE: begin
					if (rcv_q < read_length_q) begin
						res_n.read_valid = 1'b1;
						res_n.read_data  = pop_word.data;
						rcv_n            = rcv_q + 8'd1;
					end else begin
						status_n = ST_LEN;
					end
				end
				OP_STOP: begin
					// leftover bytes still in the fifo may make up the count
					if ((rcv_q < read_length_q) && (rx_sum != {1'b0, read_length_q})) begin
						status_n = ST_LEN;
					end
					done_n = 1'b1;
				end
				default: begin
					status_n = pop_word.abort_status;
					done_n   = 1'b1;
				end
			endcase
		end
		res_n.commands_finished = (cmd_n >= total_length_q);
		res_n.transfer_done     = done_n;
		res_n.result_status     = status_n;
		res_n.reset_request     = done_n && ((status_n == ST_ARB) || (status_n == ST_LEN));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_length_q <= '0;
			read_length_q  <= '0;
			total_length_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_WRITE_LENGTH: write_length_q <= cfg_data[7:0];
				CFG_READ_LENGTH:  read_length_q  <= cfg_data[7:0];
				CFG_TOTAL_LENGTH: total_length_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= '0;
			rcv_q       <= '0;
			status_q    <= ST_OK;
			done_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cmd_q    <= cmd_n;
				rcv_q    <= rcv_n;
				status_q <= status_n;
				done_q   <= done_n;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	`I2CMS_ASSERT(a_done_sticky, done_q |=> done_q, "done flag cleared without reset")
	`I2CMS_NEVER(a_reset_req_done, res_valid_q && res_q.reset_request && !res_q.transfer_done, "reset request without done")
	`I2CMS_NEVER(a_restart_read, res_valid_q && res_q.command_restart && !res_q.command_is_read, "restart on a write command")
	`I2CMS_NEVER(a_idle_cmd_clear, res_valid_q && !res_q.command_valid && (res_q.command_is_read || res_q.command_stop || (res_q.command_data != 8'd0)), "command fields set without command")
	`I2CMS_NEVER(a_pop_when_empty, pop && empty, "queue read while empty")

endmodule

// ===== sv/i2c_master_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - top level
// An accepted word passes through the event queue and the back end's output register before its result is on res.
// Throughput: one word per cycle while res_ready keeps up; the back end's output register is the limit.
// The event queue lets input words keep coming while a result waits, until the queue is full.
// Reset (arst_n low): lengths, counters, status and done flag cleared, no result.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer import i2cms_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  evt_in_t               evt,
	input  logic                  evt_valid,
	output logic                  evt_ready,
	output res_t                  res,
	output logic                  res_valid,
	input  logic                  res_ready
);

	logic full;
	logic empty;
	logic push;
	logic pop;
	evt_t push_word;
	evt_t pop_word;

	i2cms_front u_front (
		.evt       (evt),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.full      (full),
		.push      (push),
		.push_word (push_word)
	);

	i2cms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.pop_word  (pop_word),
		.empty     (empty)
	);

	i2cms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop_word  (pop_word),
		.pop       (pop),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

endmodule
